// ===== hdl/assert_macros.svh =====
// Assertion macros used by the matcher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define WPM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("wpm assertion failed");

// Next-cycle implication, disabled in reset.
`define WPM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("wpm assertion failed");

`endif

// ===== hdl/wpm_pkg.sv =====
// Shared types and constants for the wildcard pattern matcher.
`timescale 1ns / 1ps

package wpm_pkg;

	localparam int PATTERN_MAX = 64;
	localparam int IDX_W       = 6;
	localparam int LEN_W       = 7;
	localparam int SYM_W       = 8;

	localparam logic [SYM_W-1:0] SYM_STAR     = 8'd42;
	localparam logic [SYM_W-1:0] SYM_QUESTION = 8'd63;

	// Input item kind carried on tuser
	typedef enum logic [1:0] {
		OP_LOAD  = 2'd0,
		OP_TEXT  = 2'd1,
		OP_START = 2'd2
	} op_t;

	// Item handed from cell to cell along the row
	typedef struct packed {
		logic             valid;
		logic             is_text;
		logic             is_load;
		logic [SYM_W-1:0] sym;
		logic [IDX_W-1:0] idx;
		logic             last;
		logic             empty;     // text held no bytes before this one
		logic             lead;      // all earlier pattern bytes are stars
		logic             new_prev;  // new match of the prefix ending left
		logic             old_prev;  // old match of the prefix ending left
		logic             matched;
	} item_t;

endpackage

// ===== hdl/wpm_cell.sv =====
// One matcher cell: holds one pattern byte and its prefix-match bit.
`timescale 1ns / 1ps

module wpm_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      adv,
	input  logic [wpm_pkg::LEN_W-1:0] len,
	input  logic [wpm_pkg::IDX_W-1:0] cell_index,
	input  wpm_pkg::item_t            item_in,
	output wpm_pkg::item_t            item_s1
);

	logic [wpm_pkg::SYM_W-1:0] pat_q;
	logic                      bit_q;
	logic                      valid_q;
	wpm_pkg::item_t            data_q;
	logic                      is_star;
	logic                      active;
	logic                      is_end;
	logic                      lead;
	logic                      old_here;
	logic                      new_here;
	wpm_pkg::item_t            item_d;

	// Prefix recurrence for this position
	always_comb begin
		is_star  = (pat_q == wpm_pkg::SYM_STAR);
		active   = (len > {1'b0, cell_index});
		is_end   = (len == ({1'b0, cell_index} + 7'd1));
		lead     = item_in.lead & is_star;
		old_here = item_in.empty ? lead : bit_q;
		if (is_star) begin
			new_here = item_in.new_prev | old_here;
		end else begin
			new_here = item_in.old_prev &
				((pat_q == wpm_pkg::SYM_QUESTION) || (pat_q == item_in.sym));
		end
		new_here = new_here & active;

		item_d          = item_in;
		item_d.lead     = lead;
		item_d.new_prev = new_here;
		item_d.old_prev = old_here;
		if (item_in.is_text && is_end) begin
			item_d.matched = new_here;
		end
	end

	// Pattern byte, loaded by a passing load item
	always_ff @(posedge clk) begin
		if (adv && item_in.valid && item_in.is_load && (item_in.idx == cell_index)) begin
			pat_q <= item_in.sym;
		end
	end

	// Prefix bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (adv && item_in.valid && item_in.is_text) begin
			bit_q <= new_here;
		end
	end

	// Hand-off register to the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= item_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= item_d;
		end
	end

	always_comb begin
		item_s1       = data_q;
		item_s1.valid = valid_q;
	end

endmodule

// ===== hdl/wildcard_pattern_match.sv =====
// Top level of the wildcard pattern matcher: ingress, cell row, result port.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata, s_tuser (op), s_tlast
//  m_      | out       | m_tvalid/m_tready  | m_tdata (matched), m_tlast
//  cfg_    | in        | cfg_valid/cfg_ready| cfg_data (pattern_length)
//
// One item enters per cycle while s_tready is high; a text byte's result passes
// through the hand-off register of every cell of the 64-cell row before it leaves.
// A stalled result freezes the whole row, and s_tready drops with it.
// Start items act at ingress only; load items travel the row to their cell.
// Reset empties the row, sets length 1 and marks the text empty.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wildcard_pattern_match (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [15:0]               s_tdata,   // [7:0] symbol, [13:8] pattern_index
	input  logic [1:0]                s_tuser,   // [1:0] op
	input  logic                      s_tlast,   // text_last
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,   // [0] matched
	output logic                      m_tlast,   // end_of_text
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [wpm_pkg::LEN_W-1:0] cfg_data
);

	logic [wpm_pkg::LEN_W-1:0] len_q;
	logic [wpm_pkg::LEN_W-1:0] len_use;
	logic                      empty_q;
	logic                      adv;
	logic                      accept;
	wpm_pkg::op_t              op;
	wpm_pkg::item_t            head;
	wpm_pkg::item_t            chain [wpm_pkg::PATTERN_MAX];
	wpm_pkg::item_t            tail;

	// Handshakes
	assign tail      = chain[wpm_pkg::PATTERN_MAX-1];
	assign m_tvalid  = tail.valid & tail.is_text;
	assign adv       = ~m_tvalid | m_tready;
	assign s_tready  = adv;
	assign accept    = s_tvalid & adv;
	assign cfg_ready = 1'b1;
	assign op        = wpm_pkg::op_t'(s_tuser);

	// Length register, saturated to the row size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= 7'd1;
		end else if (cfg_valid) begin
			len_q <= cfg_data;
		end
	end

	assign len_use = (len_q > wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX)) ?
		wpm_pkg::LEN_W'(wpm_pkg::PATTERN_MAX) : len_q;

	// Text-empty flag, stamped on every item entering the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			empty_q <= 1'b1;
		end else if (accept) begin
			case (op)
				wpm_pkg::OP_TEXT:  empty_q <= 1'b0;
				wpm_pkg::OP_START: empty_q <= 1'b1;
				default:           empty_q <= empty_q;
			endcase
		end
	end

	// Item entering cell 0
	always_comb begin
		head          = '0;
		head.is_text  = (op == wpm_pkg::OP_TEXT);
		head.is_load  = (op == wpm_pkg::OP_LOAD);
		head.valid    = accept & (head.is_text | head.is_load);
		head.sym      = s_tdata[7:0];
		head.idx      = s_tdata[13:8];
		head.last     = s_tlast;
		head.empty    = empty_q;
		head.lead     = 1'b1;
		head.new_prev = 1'b0;
		head.old_prev = empty_q;
		head.matched  = 1'b0;
	end

	// Row of cells
	for (genvar g = 0; g < wpm_pkg::PATTERN_MAX; g++) begin : g_cell
		wpm_pkg::item_t cell_in;
		if (g == 0) begin : g_first
			assign cell_in = head;
		end else begin : g_rest
			assign cell_in = chain[g-1];
		end
		wpm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.len        (len_use),
			.cell_index (wpm_pkg::IDX_W'(g)),
			.item_in    (cell_in),
			.item_s1    (chain[g])
		);
	end

	// Result port
	assign m_tdata = {7'd0, tail.matched};
	assign m_tlast = tail.last;

	// A waiting result blocks the input side
	`WPM_ASSERT_NOW(a_stall_blocks_in, m_tvalid && !m_tready, !s_tready)
	// A text byte leaves the text non-empty
	`WPM_ASSERT_NEXT(a_text_clears_empty, accept && (op == wpm_pkg::OP_TEXT), !empty_q)
	// A start item marks the text empty
	`WPM_ASSERT_NEXT(a_start_sets_empty, accept && (op == wpm_pkg::OP_START), empty_q)
	// The row holds still while stalled
	`WPM_ASSERT_NEXT(a_row_frozen, !adv, $stable(tail.valid) && $stable(tail.matched))

endmodule
